// ===== design/acd_pkg.sv =====
// ---------------------------------------------------------------------------
// acd_pkg: shared types, constants and AES helpers for the random bit unit
// Holds the S-box, round constants, field widths and the sequencer states.
// ---------------------------------------------------------------------------
package acd_pkg;

  localparam int MaxBlocks  = 64;
  localparam int BlockBytes = 16;
  localparam int MaxBytes   = MaxBlocks * BlockBytes;
  localparam int CountW     = 48;
  localparam int NumRounds  = 14;
  localparam int NumWords   = 4 * (NumRounds + 1);

  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

  localparam logic OP_INSTANTIATE = 1'b0;
  localparam logic OP_GENERATE    = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    S_KEY    = 6'b000001,
    S_EXPAND = 6'b000010,
    S_IDLE   = 6'b000100,
    S_LOAD   = 6'b001000,
    S_ROUND  = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  // Control between sequencer and key schedule unit
  typedef struct packed {
    logic start;
    logic [3:0] rd_idx;
  } ke_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [8] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

// ===== design/acd_keyexp.sv =====
// ---------------------------------------------------------------------------
// acd_keyexp: AES-256 key schedule unit
// Produces one schedule word per cycle into the round key store.
// ---------------------------------------------------------------------------
module acd_keyexp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  acd_pkg::ke_ctrl_t    ctrl_i,
  input  logic [255:0]         key_i,
  output logic [127:0]         rd_key_o,
  output logic                 done_o
);

  logic [31:0] win_r   [8];
  logic [31:0] win_nxt [8];
  logic [31:0] rk_r    [15][4];
  logic [5:0]  idx_r, idx_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] word;
  logic [31:0] t;

  // Compute the next schedule word from the sliding window
  always_comb begin
    t = win_r[7];
    if (idx_r[2:0] == 3'd0) begin
      t = {acd_pkg::sbox(win_r[7][23:16]) ^ acd_pkg::RCON[idx_r[5:3]],
           acd_pkg::sbox(win_r[7][15:8]),
           acd_pkg::sbox(win_r[7][7:0]),
           acd_pkg::sbox(win_r[7][31:24])};
    end else if (idx_r[2:0] == 3'd4) begin
      t = {acd_pkg::sbox(win_r[7][31:24]), acd_pkg::sbox(win_r[7][23:16]),
           acd_pkg::sbox(win_r[7][15:8]), acd_pkg::sbox(win_r[7][7:0])};
    end
    word = (idx_r < 6'd8) ? win_r[idx_r[2:0]] : (win_r[0] ^ t);
  end

  // Advance the window and counter
  always_comb begin
    win_nxt  = win_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctrl_i.start) begin
      for (int j = 0; j < 8; j++) begin
        win_nxt[j] = key_i[255 - 32*j -: 32];
      end
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (idx_r >= 6'd8) begin
        for (int j = 0; j < 7; j++) begin
          win_nxt[j] = win_r[j+1];
        end
        win_nxt[7] = word;
      end
      if (idx_r == 6'(acd_pkg::NumWords - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // Hold window and store the schedule word
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (busy_r && !ctrl_i.start) begin
      rk_r[idx_r[5:2]][idx_r[1:0]] <= word;
    end
  end

  assign rd_key_o = {rk_r[ctrl_i.rd_idx][0], rk_r[ctrl_i.rd_idx][1],
                     rk_r[ctrl_i.rd_idx][2], rk_r[ctrl_i.rd_idx][3]};
  assign done_o   = done_r;

endmodule

// ===== design/acd_round.sv =====
// ---------------------------------------------------------------------------
// acd_round: one AES encryption round
// SubBytes, ShiftRows, MixColumns (skipped on the final round), AddRoundKey.
// ---------------------------------------------------------------------------
module acd_round (
  input  logic [127:0] st_i,
  input  logic [127:0] rk_i,
  input  logic         final_i,
  output logic [127:0] st_o
);

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [7:0] all;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = st_i[127 - 8*i -: 8];
    end
    // Substitute and shift rows
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4*c] = acd_pkg::sbox(s[i + 4*((c + i) % 4)]);
      end
    end
    // Mix columns
    for (int c = 0; c < 4; c++) begin
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ all ^ acd_pkg::xtime(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ all ^ acd_pkg::xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ all ^ acd_pkg::xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ all ^ acd_pkg::xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) begin
      st_o[127 - 8*i -: 8] = (final_i ? t[i] : m[i]) ^ rk_i[127 - 8*i -: 8];
    end
  end

endmodule

// ===== design/aes256_ctr_drbg_unit.sv =====
// ---------------------------------------------------------------------------
// aes256_ctr_drbg_unit: AES-256 counter-mode random bit generator, no df
// Instantiate and generate requests over one iterated AES-256 round unit.
// ---------------------------------------------------------------------------
// One AES round is done per cycle: each encrypted block takes a load step
// (initial AddRoundKey) plus 14 round steps, and a generated block adds an
// output step that waits for out_tready. After every key change the key
// schedule runs (a start state, then expansion until done), including
// once after reset before the first request is taken. An instantiate request
// expands the zero key, encrypts three update blocks and expands the new key;
// a generate request of B blocks outputs B blocks, then encrypts three update
// blocks and expands the new key. The block takes one request at a time and
// holds in_tready low until the request has fully finished.
// ---------------------------------------------------------------------------
module aes256_ctr_drbg_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // seed_word_0 [63:0] .. seed_word_5 [383:320], byte_count [394:384]
  input  logic [399:0] in_tdata,
  // opcode
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // random_high [63:0], random_low [127:64], bytes_valid [132:128],
  // request_count [180:133]
  output logic [183:0] out_tdata,
  output logic         out_tlast
);

  acd_pkg::state_t   state_r, state_nxt;
  acd_pkg::ke_ctrl_t ke_ctrl;

  logic [255:0] key_r, key_nxt;
  logic [127:0] v_r, v_nxt;
  logic [127:0] st_r, st_nxt;
  logic [127:0] tmp0_r, tmp0_nxt, tmp1_r, tmp1_nxt;
  logic [383:0] data_r, data_nxt;
  logic [10:0]  rem_r, rem_nxt;
  logic [3:0]   round_r, round_nxt;
  logic [1:0]   upd_r, upd_nxt;
  logic         gen_r, gen_nxt;
  logic         pend_r, pend_nxt;
  logic [47:0]  count_r, count_nxt;
  logic [127:0] rd_key, round_out;
  logic         ke_done;
  logic [10:0]  req_bytes;
  logic [4:0]   take;
  logic         last_blk;

  acd_keyexp u_keyexp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl_i   (ke_ctrl),
    .key_i    (key_r),
    .rd_key_o (rd_key),
    .done_o   (ke_done)
  );

  acd_round u_round (
    .st_i    (st_r),
    .rk_i    (rd_key),
    .final_i (round_r == 4'(acd_pkg::NumRounds)),
    .st_o    (round_out)
  );

  assign req_bytes = (in_tdata[394:384] > 11'(acd_pkg::MaxBytes))
                     ? 11'(acd_pkg::MaxBytes) : in_tdata[394:384];
  assign take      = (rem_r < 11'(acd_pkg::BlockBytes)) ? rem_r[4:0]
                     : 5'(acd_pkg::BlockBytes);
  assign last_blk  = (rem_r <= 11'(acd_pkg::BlockBytes));

  assign ke_ctrl.start  = (state_r == acd_pkg::S_KEY);
  assign ke_ctrl.rd_idx = (state_r == acd_pkg::S_LOAD) ? 4'd0 : round_r;

  assign in_tready  = (state_r == acd_pkg::S_IDLE);
  assign out_tvalid = (state_r == acd_pkg::S_OUT);
  assign out_tdata  = {3'b000, count_r, take, st_r[63:0], st_r[127:64]};
  assign out_tlast  = last_blk;

  // Sequence requests over the shared round unit
  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    v_nxt     = v_r;
    st_nxt    = st_r;
    tmp0_nxt  = tmp0_r;
    tmp1_nxt  = tmp1_r;
    data_nxt  = data_r;
    rem_nxt   = rem_r;
    round_nxt = round_r;
    upd_nxt   = upd_r;
    gen_nxt   = gen_r;
    pend_nxt  = pend_r;
    count_nxt = count_r;
    case (state_r)
      acd_pkg::S_KEY: begin
        state_nxt = acd_pkg::S_EXPAND;
      end
      acd_pkg::S_EXPAND: begin
        if (ke_done) begin
          pend_nxt  = 1'b0;
          gen_nxt   = 1'b0;
          upd_nxt   = '0;
          state_nxt = pend_r ? acd_pkg::S_LOAD : acd_pkg::S_IDLE;
        end
      end
      acd_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == acd_pkg::OP_INSTANTIATE) begin
            key_nxt   = '0;
            v_nxt     = '0;
            data_nxt  = {in_tdata[63:0], in_tdata[127:64], in_tdata[191:128],
                         in_tdata[255:192], in_tdata[319:256], in_tdata[383:320]};
            pend_nxt  = 1'b1;
            count_nxt = 48'd1;
            state_nxt = acd_pkg::S_KEY;
          end else begin
            data_nxt  = '0;
            rem_nxt   = req_bytes;
            gen_nxt   = (req_bytes != 11'd0);
            upd_nxt   = '0;
            count_nxt = (count_r == acd_pkg::COUNT_MAX) ? count_r : count_r + 48'd1;
            state_nxt = acd_pkg::S_LOAD;
          end
        end
      end
      acd_pkg::S_LOAD: begin
        v_nxt     = v_r + 128'd1;
        st_nxt    = v_nxt ^ rd_key;
        round_nxt = 4'd1;
        state_nxt = acd_pkg::S_ROUND;
      end
      acd_pkg::S_ROUND: begin
        st_nxt = round_out;
        if (round_r == 4'(acd_pkg::NumRounds)) begin
          if (gen_r) begin
            state_nxt = acd_pkg::S_OUT;
          end else if (upd_r == 2'd2) begin
            key_nxt   = {tmp0_r, tmp1_r} ^ data_r[383:128];
            v_nxt     = round_out ^ data_r[127:0];
            state_nxt = acd_pkg::S_KEY;
          end else begin
            if (upd_r == 2'd0) begin
              tmp0_nxt = round_out;
            end else begin
              tmp1_nxt = round_out;
            end
            upd_nxt   = upd_r + 2'd1;
            state_nxt = acd_pkg::S_LOAD;
          end
        end else begin
          round_nxt = round_r + 4'd1;
        end
      end
      acd_pkg::S_OUT: begin
        if (out_tready) begin
          rem_nxt   = rem_r - 11'(take);
          if (last_blk) begin
            gen_nxt = 1'b0;
          end
          state_nxt = acd_pkg::S_LOAD;
        end
      end
      default: begin
        state_nxt = acd_pkg::S_IDLE;
      end
    endcase
  end

  // Hold control state; reset clears key, counter and request count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acd_pkg::S_KEY;
      key_r   <= '0;
      v_r     <= '0;
      count_r <= '0;
      pend_r  <= 1'b0;
      gen_r   <= 1'b0;
      upd_r   <= '0;
      round_r <= '0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
      v_r     <= v_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      gen_r   <= gen_nxt;
      upd_r   <= upd_nxt;
      round_r <= round_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // Hold datapath
  always_ff @(posedge clk) begin
    st_r   <= st_nxt;
    tmp0_r <= tmp0_nxt;
    tmp1_r <= tmp1_nxt;
    data_r <= data_nxt;
  end

endmodule

// ===== dv/drbg_checker.sv =====
// ---------------------------------------------------------------------------
// drbg_checker: request predictor and result scoreboard for the DRBG unit
// Watches both streams, models the AES-256 counter-mode generator state on
// each accepted request and compares every accepted output block field by
// field.
// ---------------------------------------------------------------------------
module drbg_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [399:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [183:0] out_tdata,
  input  logic         out_tlast,
  output int           fail_count,
  output int           blocks_pending
);

  typedef struct packed {
    logic [63:0]                hi;
    logic [63:0]                lo;
    logic [4:0]                 nbytes;
    logic                       last;
    logic [acd_pkg::CountW-1:0] count;
  } block_t;

  block_t        block_q[$];
  logic [255:0]  drbg_key;
  logic [127:0]  drbg_v;
  logic [acd_pkg::CountW-1:0] req_count;
  logic [127:0]  rkeys [15];

  assign blocks_pending = block_q.size();

  // Expand the 256-bit key into fifteen round keys, byte 0 in the top bits
  function automatic void expand_keys();
    logic [31:0] w [60];
    logic [31:0] t;
    for (int i = 0; i < 8; i++) w[i] = drbg_key[255-32*i -: 32];
    for (int i = 8; i < 60; i++) begin
      t = w[i-1];
      if (i % 8 == 0) begin
        t = {acd_pkg::SBOX[t[23:16]] ^ acd_pkg::RCON[i/8], acd_pkg::SBOX[t[15:8]],
             acd_pkg::SBOX[t[7:0]], acd_pkg::SBOX[t[31:24]]};
      end else if (i % 8 == 4) begin
        t = {acd_pkg::SBOX[t[31:24]], acd_pkg::SBOX[t[23:16]],
             acd_pkg::SBOX[t[15:8]], acd_pkg::SBOX[t[7:0]]};
      end
      w[i] = w[i-8] ^ t;
    end
    for (int r = 0; r < 15; r++) rkeys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic logic [7:0] gmul2(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Encrypt one block; byte i sits at bits 127-8i
  function automatic logic [127:0] aes_encrypt(logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ rkeys[0][127-8*i -: 8];
    for (int r = 1; r <= 14; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i+4*c] = acd_pkg::SBOX[s[i + 4*((c+i)%4)]];
      if (r < 14) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ all ^ gmul2(a0 ^ a1);
          t[4*c+1] = a1 ^ all ^ gmul2(a1 ^ a2);
          t[4*c+2] = a2 ^ all ^ gmul2(a2 ^ a3);
          t[4*c+3] = a3 ^ all ^ gmul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rkeys[r][127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  function automatic logic [127:0] step_counter();
    drbg_v = drbg_v + 128'd1;
    return aes_encrypt(drbg_v);
  endfunction

  // Refresh key and counter from three keystream blocks mixed with the data
  function automatic void reseed_state(logic [383:0] mix);
    logic [383:0] ks;
    for (int i = 0; i < 3; i++) ks[383-128*i -: 128] = step_counter();
    ks = ks ^ mix;
    drbg_key = ks[383:128];
    drbg_v   = ks[127:0];
    expand_keys();
  endfunction

  function automatic void predict_request(logic op, logic [399:0] d);
    logic [383:0] seed;
    int n, nblk, left;
    block_t b;
    block_t blks[$];
    for (int i = 0; i < 6; i++) seed[383-64*i -: 64] = d[64*i +: 64];
    if (op == acd_pkg::OP_INSTANTIATE) begin
      drbg_key = '0;
      drbg_v   = '0;
      expand_keys();
      reseed_state(seed);
      req_count = 48'd1;
      return;
    end
    n = int'(d[394:384]);
    if (n > acd_pkg::MaxBytes) n = acd_pkg::MaxBytes;
    nblk = (n + acd_pkg::BlockBytes - 1) / acd_pkg::BlockBytes;
    left = n;
    for (int i = 0; i < nblk; i++) begin
      {b.hi, b.lo} = step_counter();
      b.nbytes = (left < acd_pkg::BlockBytes) ? 5'(left) : 5'(acd_pkg::BlockBytes);
      b.last   = (i == nblk - 1);
      left    -= int'(b.nbytes);
      blks.push_back(b);
    end
    reseed_state('0);
    if (req_count != acd_pkg::COUNT_MAX) req_count++;
    foreach (blks[i]) begin
      blks[i].count = req_count;
      block_q.push_back(blks[i]);
    end
  endfunction

  initial begin
    fail_count = 0;
    drbg_key = '0;
    drbg_v = '0;
    req_count = '0;
    expand_keys();
  end

  // Predict on accepted requests, compare on accepted blocks
  always @(posedge clk) begin
    block_t got, exp_b;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got = {out_tdata[63:0], out_tdata[127:64], out_tdata[132:128], out_tlast,
               out_tdata[180:133]};
        if (block_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected block %h", got);
        end else begin
          exp_b = block_q.pop_front();
          if (got != exp_b) begin
            fail_count++;
            if (fail_count <= 10)
              $display("block mismatch: hi %h/%h lo %h/%h bytes %0d/%0d last %b/%b cnt %h/%h",
                exp_b.hi, got.hi, exp_b.lo, got.lo, exp_b.nbytes, got.nbytes,
                exp_b.last, got.last, exp_b.count, got.count);
          end
        end
      end
    end
  end

endmodule

// ===== dv/tb_aes256_ctr_drbg_unit.sv =====
// ---------------------------------------------------------------------------
// tb_aes256_ctr_drbg_unit: stream testbench for the random bit unit
// Drives directed and random instantiate/generate requests with random
// idling on both sides and takes the verdict from the checker.
// ---------------------------------------------------------------------------
module tb_aes256_ctr_drbg_unit;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [399:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [183:0] out_tdata;
  logic         out_tlast;
  int           fail_count;
  int           blocks_pending;
  int           send_idle = 22;
  int           recv_idle = 83;
  bit           hold_off = 1'b0;

  always #6 clk = ~clk;

  aes256_ctr_drbg_unit u_dut (.*);

  drbg_checker u_chk (.*);

  // Drive the receiver ready, with a long hold-off when asked
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Offer one request, idling at random beforehand
  task automatic send_request(logic op, logic [383:0] seed, logic [10:0] nbytes);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'd0, nbytes, seed};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [383:0] rand_seed();
    logic [383:0] s;
    for (int i = 0; i < 12; i++) s[32*i +: 32] = $urandom;
    return s;
  endfunction

  function automatic logic [10:0] rand_len();
    int k;
    k = $urandom_range(99);
    if (k < 70) return 11'($urandom_range(64));
    if (k < 90) return 11'($urandom_range(acd_pkg::MaxBytes));
    return 11'($urandom_range(2047));
  endfunction

  // Stop offering and wait until the last request has fully finished
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (blocks_pending != 0 || !in_tready) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: generate on the reset state, zero length, extremes
    send_request(acd_pkg::OP_GENERATE, '0, 11'd16);
    send_request(acd_pkg::OP_GENERATE, '0, 11'd0);
    send_request(acd_pkg::OP_INSTANTIATE, '0, 11'd0);
    send_request(acd_pkg::OP_GENERATE, '0, 11'd1);
    send_request(acd_pkg::OP_INSTANTIATE, '1, 11'h7ff);
    send_request(acd_pkg::OP_GENERATE, '1, 11'd17);
    send_request(acd_pkg::OP_GENERATE, '0, 11'd1024);
    send_request(acd_pkg::OP_GENERATE, '0, 11'd1025);
    send_request(acd_pkg::OP_GENERATE, '1, 11'h7ff);
    send_request(acd_pkg::OP_GENERATE, '0, 11'd15);
    send_request(acd_pkg::OP_INSTANTIATE, rand_seed(), 11'h555);
    send_request(acd_pkg::OP_GENERATE, rand_seed(), 11'd0);
    send_request(acd_pkg::OP_GENERATE, rand_seed(), 11'd31);
    // Pause until all blocks are out
    drain();
    // Long receiver hold-off while requests keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (1500) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 4; i++)
        send_request(acd_pkg::OP_GENERATE, rand_seed(), 11'd48);
    join
    // Random: mostly generates, occasional reseed
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle = 83;
        recv_idle = 22;
      end else if (ph == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int i = 0; i < 130; i++)
        send_request(($urandom_range(9) == 0) ? acd_pkg::OP_INSTANTIATE
                                              : acd_pkg::OP_GENERATE,
                     rand_seed(), rand_len());
    end
    drain();
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Give up after a generous fixed time
  initial begin
    #120000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== aes256_ctr_drbg_unit.f =====
design/acd_pkg.sv
design/acd_keyexp.sv
design/acd_round.sv
design/aes256_ctr_drbg_unit.sv
dv/drbg_checker.sv
dv/tb_aes256_ctr_drbg_unit.sv
